### rtl/speed_hysteresis_recording_gate_defines.svh
// Assertion macros for the speed hysteresis recording gate.
`ifndef SPEED_HYSTERESIS_RECORDING_GATE_DEFINES_SVH
`define SPEED_HYSTERESIS_RECORDING_GATE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHRG_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("Same-cycle check failed.");

// The consequent must hold in the cycle after the antecedent.
`define SHRG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("Next-cycle check failed.");

`endif

### rtl/shrg_pkg.sv
// Types and constants of the speed hysteresis recording gate.
package shrg_pkg;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned SPEED_W = 12;
	localparam int unsigned HOLD_W  = 24;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 24;

	typedef logic [TIME_W-1:0]  time_ms_t;
	typedef logic [SPEED_W-1:0] speed_t;
	typedef logic [HOLD_W-1:0]  hold_ms_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENTER_SPEED   = 2'd0,
		REG_EXIT_SPEED    = 2'd1,
		REG_FIX_HOLD_TIME = 2'd2,
		REG_COAST_TIME    = 2'd3
	} cfg_reg_t;

	localparam speed_t   ENTER_SPEED_RST   = 12'd150;
	localparam speed_t   EXIT_SPEED_RST    = 12'd50;
	localparam hold_ms_t FIX_HOLD_TIME_RST = 24'd3000;
	localparam hold_ms_t COAST_TIME_RST    = 24'd30000;

endpackage

### rtl/speed_hysteresis_recording_gate.sv
// Speed hysteresis recording gate: input register, one stage of update logic, result register.
// An accepted item is held in the input register, and its result is then written to the result register.
// One item is taken per cycle; the input stalls only while a stalled result holds the output.
// The gate state and the result register are written at the same edge, so back-to-back items
// see the state left by the item before them.
// Asynchronous reset clears the gate state, empties both stages and loads the registers' defaults.
module speed_hysteresis_recording_gate
	import shrg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [TIME_W-1:0]     now_time,
	input  logic                  sample_present,
	input  logic [SPEED_W-1:0]    speed,
	input  logic                  imu_still,
	input  logic                  gps_alive,
	input  logic                  restart,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic                  recording,
	output logic                  gate_open
);

`include "speed_hysteresis_recording_gate_defines.svh"

	speed_t   enter_speed_q;
	speed_t   exit_speed_q;
	hold_ms_t fix_hold_time_q;
	hold_ms_t coast_time_q;

	logic     gate_is_open_q;
	logic     below_exit_q;
	time_ms_t below_start_time_q;
	logic     seen_sample_q;
	time_ms_t last_sample_time_q;

	logic     valid_s1;
	time_ms_t now_time_s1;
	logic     sample_present_s1;
	speed_t   speed_s1;
	logic     imu_still_s1;
	logic     gps_alive_s1;
	logic     restart_s1;

	logic     result_valid_q;
	logic     recording_q;
	logic     gate_open_q;

	logic     advance;
	logic     take_item;
	logic     compute;

	logic     gate_0;
	logic     below_0;
	time_ms_t bst_0;
	logic     seen_0;
	time_ms_t lst_0;

	logic     gate_1;
	logic     below_1;
	time_ms_t bst_1;
	logic     seen_1;
	time_ms_t lst_1;

	time_ms_t coast_age;
	time_ms_t sample_age;
	logic     coast_done;
	logic     fresh;
	logic     rec_next;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enter_speed_q   <= ENTER_SPEED_RST;
			exit_speed_q    <= EXIT_SPEED_RST;
			fix_hold_time_q <= FIX_HOLD_TIME_RST;
			coast_time_q    <= COAST_TIME_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ENTER_SPEED:   enter_speed_q   <= cfg_data[SPEED_W-1:0];
				REG_EXIT_SPEED:    exit_speed_q    <= cfg_data[SPEED_W-1:0];
				REG_FIX_HOLD_TIME: fix_hold_time_q <= cfg_data[HOLD_W-1:0];
				REG_COAST_TIME:    coast_time_q    <= cfg_data[HOLD_W-1:0];
				default: ;
			endcase
		end
	end

	assign advance    = !result_valid_q || !result_stall;
	assign compute    = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;
	assign take_item  = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_item) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_item) begin
			now_time_s1       <= now_time;
			sample_present_s1 <= sample_present;
			speed_s1          <= speed;
			imu_still_s1      <= imu_still;
			gps_alive_s1      <= gps_alive;
			restart_s1        <= restart;
		end
	end

	// A restart clears the state before the item's sample is applied.
	always_comb begin
		gate_0  = restart_s1 ? 1'b0 : gate_is_open_q;
		below_0 = restart_s1 ? 1'b0 : below_exit_q;
		bst_0   = restart_s1 ? '0 : below_start_time_q;
		seen_0  = restart_s1 ? 1'b0 : seen_sample_q;
		lst_0   = restart_s1 ? '0 : last_sample_time_q;
	end

	// Gate update. The enter test is made first, so crossed thresholds still open the gate.
	always_comb begin
		gate_1  = gate_0;
		below_1 = below_0;
		bst_1   = bst_0;
		seen_1  = seen_0;
		lst_1   = lst_0;
		if (sample_present_s1) begin
			seen_1 = 1'b1;
			lst_1  = now_time_s1;
			if (speed_s1 >= enter_speed_q) begin
				below_1 = 1'b0;
			end else if (speed_s1 < exit_speed_q) begin
				below_1 = 1'b1;
				if (!below_0) begin
					bst_1 = now_time_s1;
				end
			end else begin
				below_1 = 1'b0;
			end
		end
		coast_age  = now_time_s1 - bst_1;
		sample_age = now_time_s1 - lst_1;
		coast_done = coast_age >= {{(TIME_W-HOLD_W){1'b0}}, coast_time_q};
		fresh      = seen_1 && (sample_age <= {{(TIME_W-HOLD_W){1'b0}}, fix_hold_time_q});
		if (sample_present_s1) begin
			if (speed_s1 >= enter_speed_q) begin
				gate_1 = 1'b1;
			end else if ((speed_s1 < exit_speed_q) && coast_done) begin
				gate_1 = 1'b0;
			end
		end
		if (!fresh) begin
			if (!gps_alive_s1) begin
				rec_next = !imu_still_s1;
			end else if (!seen_1 || !gate_1) begin
				rec_next = 1'b0;
			end else begin
				rec_next = !imu_still_s1;
			end
		end else begin
			rec_next = gate_1 && !(below_1 && coast_done);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_is_open_q     <= 1'b0;
			below_exit_q       <= 1'b0;
			below_start_time_q <= '0;
			seen_sample_q      <= 1'b0;
			last_sample_time_q <= '0;
		end else if (compute) begin
			gate_is_open_q     <= gate_1;
			below_exit_q       <= below_1;
			below_start_time_q <= bst_1;
			seen_sample_q      <= seen_1;
			last_sample_time_q <= lst_1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (compute) begin
			recording_q <= rec_next;
			gate_open_q <= gate_1;
		end
	end

	assign result_valid = result_valid_q;
	assign recording    = recording_q;
	assign gate_open    = gate_open_q;

	`SHRG_ASSERT_NOW(a_stall_only_when_full, item_stall, valid_s1)
	`SHRG_ASSERT_NEXT(a_result_matches_state, compute, gate_open_q == gate_is_open_q)
	`SHRG_ASSERT_NEXT(a_restart_closes_gate,
		compute && restart_s1 && !sample_present_s1,
		!gate_is_open_q && !below_exit_q && !seen_sample_q)

endmodule
